// File: rtl/stt_pkg.sv
// stt_pkg: shared types, codes and byte classes for the source text tokenizer
// no dependencies; used by every rtl file of the block but stt_if

package stt_pkg;

  // lexer mode codes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_RUN  = 3'd1;
  localparam logic [2:0] MODE_EQ   = 3'd2;
  localparam logic [2:0] MODE_CHR  = 3'd3;
  localparam logic [2:0] MODE_ESC  = 3'd4;

  // result kind codes
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_CLOSE  = 1'b1;

  // character constants
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_N    = 8'h6E;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_NUL        = 8'h00;

  // most results one byte can cause
  localparam int STT_MAX_RESULTS = 3;
  // default depth of the queue between front and back
  localparam int STT_QUEUE_DEPTH = 4;

  // results planned for one accepted byte
  typedef struct packed {
    logic [1:0]                          cnt;
    logic [STT_MAX_RESULTS-1:0]          kind;
    logic [STT_MAX_RESULTS-1:0][7:0]     data;
  } res_plan_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    logic r;
    case (c)
      8'h2B, 8'h2D, 8'h3B, 8'h2E, 8'h28, 8'h29, 8'h3F,
      8'h7B, 8'h7D, 8'h40, 8'h2A, 8'h26, 8'h2F, 8'h2C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // add one result to a plan
  function automatic res_plan_t plan_push(input res_plan_t p, input logic k,
                                          input logic [7:0] b);
    res_plan_t q;
    q = p;
    if (p.cnt != 2'(STT_MAX_RESULTS)) begin
      q.kind[p.cnt] = k;
      q.data[p.cnt] = b;
      q.cnt         = p.cnt + 2'd1;
    end
    return q;
  endfunction

endpackage

// File: rtl/stt_if.sv
// stt_if: valid/ready channel interfaces for tokenizer bytes and results
// no dependencies

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       result_kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output result_kind,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input result_kind,
                input last_of_run, output ready);
endinterface

// File: rtl/stt_front.sv
// stt_front: accepts bytes, runs the lexer state and plans the results of each byte
// depends on stt_pkg and stt_in_if

module stt_front
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  stt_in_if.sink     in_if,
  input  logic       q_full,
  output logic       push,
  output res_plan_t  plan
);

  logic [2:0] mode_r, mode_nxt;
  logic       digit_r, digit_nxt;
  logic       open_r, open_nxt;
  logic       accept;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;

  // lexer step: plan results and next state
  always_comb begin
    res_plan_t  p;
    logic       do_close;
    logic       do_start;
    logic [7:0] c;
    p         = '0;
    do_close  = 1'b0;
    do_start  = 1'b0;
    c         = in_if.in_byte;
    mode_nxt  = mode_r;
    digit_nxt = digit_r;
    open_nxt  = open_r;

    if (in_if.end_of_text) begin
      do_close = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_RUN: begin
          if (is_word_byte(c) || ((c == CH_DOT) && digit_r)) begin
            p         = plan_push(p, KIND_APPEND, c);
            digit_nxt = is_digit(c);
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_EQ: begin
          if (c == CH_EQUAL) begin
            p = plan_push(p, KIND_APPEND, c);
          end else begin
            do_start = 1'b1;
          end
          do_close = 1'b1;
        end
        MODE_CHR: begin
          if (c == CH_QUOTE) begin
            do_close = 1'b1;
          end else if (c == CH_BACKSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            p = plan_push(p, KIND_APPEND, c);
          end
        end
        MODE_ESC: begin
          if (c == CH_LOWER_N) begin
            p = plan_push(p, KIND_APPEND, CH_NEWLINE);
          end else if (c == CH_ZERO) begin
            p = plan_push(p, KIND_APPEND, CH_NUL);
          end else if ((c == CH_QUOTE) || (c == CH_BACKSLASH)) begin
            p = plan_push(p, KIND_APPEND, c);
          end
          mode_nxt = MODE_CHR;
        end
        default: begin
          mode_nxt = MODE_IDLE;
          do_start = 1'b1;
        end
      endcase
    end

    // close any pending word
    if (do_close) begin
      if (open_nxt) p = plan_push(p, KIND_CLOSE, 8'h00);
      open_nxt  = 1'b0;
      digit_nxt = 1'b0;
      mode_nxt  = MODE_IDLE;
    end

    // begin a new word with this byte
    if (do_start) begin
      if (is_word_byte(c)) begin
        p         = plan_push(p, KIND_APPEND, c);
        open_nxt  = 1'b1;
        digit_nxt = is_digit(c);
        mode_nxt  = MODE_RUN;
      end else if (is_single(c)) begin
        p         = plan_push(p, KIND_APPEND, c);
        p         = plan_push(p, KIND_CLOSE, 8'h00);
        open_nxt  = 1'b0;
        digit_nxt = 1'b0;
        mode_nxt  = MODE_IDLE;
      end else if (c == CH_EQUAL) begin
        p        = plan_push(p, KIND_APPEND, c);
        open_nxt = 1'b1;
        mode_nxt = MODE_EQ;
      end else if (c == CH_QUOTE) begin
        p        = plan_push(p, KIND_APPEND, c);
        open_nxt = 1'b1;
        mode_nxt = MODE_CHR;
      end
    end

    plan = p;
  end

  // bytes with no results never enter the queue
  assign push = accept && (plan.cnt != 2'd0);

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      digit_r <= 1'b0;
      open_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      digit_r <= digit_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

// File: rtl/stt_queue.sv
// stt_queue: small first-in first-out buffer of result plans between front and back
// depends on stt_pkg

module stt_queue
  import stt_pkg::*;
#(
  parameter int DEPTH = STT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_plan_t push_plan,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output res_plan_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_plan_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_plan;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

// File: rtl/stt_back.sv
// stt_back: holds one result plan and sends its results one per cycle while out_if is ready
// depends on stt_pkg and stt_out_if

module stt_back
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  res_plan_t  q_head,
  output logic       pop,
  stt_out_if.source  out_if
);

  res_plan_t  cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       last;
  logic       sent;

  assign last = (idx_r == (cur_r.cnt - 2'd1));
  assign sent = cur_valid_r && out_if.ready;
  assign pop  = q_not_empty && (!cur_valid_r || (sent && last));

  // result drive from the held plan
  assign out_if.valid       = cur_valid_r;
  assign out_if.out_byte    = cur_r.data[idx_r];
  assign out_if.result_kind = cur_r.kind[idx_r];
  assign out_if.last_of_run = last;

  // plan register and slot counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (sent) begin
      if (last) begin
        cur_valid_r <= 1'b0;
        idx_r       <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_head;
  end

endmodule

// File: rtl/source_text_tokenizer.sv
// source_text_tokenizer: top level, front lexer, plan queue and result sender
// depends on stt_pkg, stt_if, stt_front, stt_queue, stt_back
//
//   channel  direction  handshake          payload
//   in_if    sink       valid / ready      in_byte[7:0], end_of_text
//   out_if   source     valid / ready      out_byte[7:0], result_kind, last_of_run
//
// a byte is taken every cycle while the plan queue has room; its zero to three
// results leave one per cycle while out_if is ready, so sustained throughput is
// set by the result sender.
// the first result of a byte is registered in the plan queue, then in the sender's plan register.
// rst_n is synchronous and clears lexer state, queue pointers and the sender.
// a stalled out_if holds the current result; the queue absorbs bytes meanwhile.

module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int QUEUE_DEPTH = STT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_if,
  stt_out_if.source out_if
);

  res_plan_t plan;
  res_plan_t head;
  logic      push;
  logic      q_full;
  logic      q_not_empty;
  logic      pop;

  stt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .push   (push),
    .plan   (plan)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (plan),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  stt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .pop         (pop),
    .out_if      (out_if)
  );

endmodule

// File: verif/source_text_tokenizer_tb.sv
// source_text_tokenizer_tb: self-checking bench for the source text tokenizer
// depends on stt_pkg, stt_if and the source_text_tokenizer rtl
// directed run, equals, literal and end-of-text cases, then a random source stream

`timescale 1ns / 1ps

module source_text_tokenizer_tb
  import stt_pkg::*;
();

  // one expected word result
  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } token_result_t;

  logic clk = 1'b0;
  logic rst_n;

  stt_in_if  in_if ();
  stt_out_if out_if ();

  source_text_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // lexer state as predicted
  logic [2:0] tok_mode;
  logic       tok_after_digit;
  logic       tok_word_open;

  token_result_t step_results[$];
  token_result_t token_expect_q[$];

  int  mismatch_count;
  int  sent_requests;
  bit  idle_on;
  string sym_chars = "+-;.()?{}@*&/,";

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_if.ready <= !idle_on || ($urandom_range(0, 99) >= 36);
  end

  // byte classes
  function automatic logic tok_is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic tok_is_word(input logic [7:0] c);
    return tok_is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == CH_UNDERSCORE;
  endfunction

  function automatic logic tok_is_symbol(input logic [7:0] c);
    case (c)
      "+", "-", ";", ".", "(", ")", "?", "{", "}", "@", "*", "&", "/", ",": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_result(input logic kind, input logic [7:0] b);
    token_result_t r;
    r.data = b;
    r.kind = kind;
    r.last = 1'b0;
    if (step_results.size() < 3) step_results = {step_results, r};
  endfunction

  function automatic void close_token();
    if (tok_word_open) add_result(KIND_CLOSE, 8'h00);
    tok_word_open   = 1'b0;
    tok_after_digit = 1'b0;
    tok_mode        = MODE_IDLE;
  endfunction

  // first byte of a new word
  function automatic void open_token(input logic [7:0] c);
    if (tok_is_word(c)) begin
      add_result(KIND_APPEND, c);
      tok_word_open   = 1'b1;
      tok_after_digit = tok_is_digit(c);
      tok_mode        = MODE_RUN;
    end else if (tok_is_symbol(c)) begin
      add_result(KIND_APPEND, c);
      tok_word_open = 1'b1;
      close_token();
    end else if (c == CH_EQUAL) begin
      add_result(KIND_APPEND, c);
      tok_word_open = 1'b1;
      tok_mode      = MODE_EQ;
    end else if (c == CH_QUOTE) begin
      add_result(KIND_APPEND, c);
      tok_word_open = 1'b1;
      tok_mode      = MODE_CHR;
    end
  endfunction

  // advance the predicted lexer by one request and queue its results
  function automatic int predict_tokens(input logic [7:0] c, input logic eot);
    token_result_t r;
    step_results.delete();
    if (eot) begin
      close_token();
    end else begin
      case (tok_mode)
        MODE_RUN: begin
          if (tok_is_word(c) || (c == CH_DOT && tok_after_digit)) begin
            add_result(KIND_APPEND, c);
            tok_after_digit = tok_is_digit(c);
          end else begin
            close_token();
            open_token(c);
          end
        end
        MODE_EQ: begin
          if (c == CH_EQUAL) begin
            add_result(KIND_APPEND, c);
            close_token();
          end else begin
            close_token();
            open_token(c);
          end
        end
        MODE_CHR: begin
          if (c == CH_QUOTE) close_token();
          else if (c == CH_BACKSLASH) tok_mode = MODE_ESC;
          else add_result(KIND_APPEND, c);
        end
        MODE_ESC: begin
          if (c == CH_LOWER_N) add_result(KIND_APPEND, CH_NEWLINE);
          else if (c == CH_ZERO) add_result(KIND_APPEND, CH_NUL);
          else if (c == CH_QUOTE || c == CH_BACKSLASH) add_result(KIND_APPEND, c);
          tok_mode = MODE_CHR;
        end
        default: begin
          tok_mode = MODE_IDLE;
          open_token(c);
        end
      endcase
    end
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      r.last = (i == step_results.size() - 1);
      token_expect_q = {token_expect_q, r};
    end
    return step_results.size();
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch: %0s at %0t ns, expected %0h, got %0h", what, $time, want, got);
    mismatch_count++;
  endtask

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    token_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (token_expect_q.size() == 0) begin
        report_mismatch("result with none expected", 0, out_if.out_byte);
      end else begin
        want = token_expect_q.pop_front();
        if (out_if.out_byte !== want.data)
          report_mismatch("out_byte", want.data, out_if.out_byte);
        if (out_if.result_kind !== want.kind)
          report_mismatch("result_kind", want.kind, out_if.result_kind);
        if (out_if.last_of_run !== want.last)
          report_mismatch("last_of_run", want.last, out_if.last_of_run);
      end
    end
  end

  // send one request; returns right after the edge that accepts it
  task automatic send_item(input logic [7:0] c, input logic eot);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 36) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.in_byte     <= c;
    in_if.end_of_text <= eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    void'(predict_tokens(c, eot));
    sent_requests++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // hold off the sender until every expected result has come
  task automatic wait_for_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (token_expect_q.size() > 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_word_byte();
    case ($urandom_range(0, 3))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      2: return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return CH_UNDERSCORE;
    endcase
  endfunction

  function automatic logic [7:0] rand_separator();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return 8'h09;
      2: return CH_NEWLINE;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // char literal with random plain bytes and escapes, closed by a quote or by end of text
  task automatic send_char_literal(input bit terminated);
    logic [7:0] c;
    send_item(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1)) begin
        send_item(CH_BACKSLASH, 1'b0);
        case ($urandom_range(0, 4))
          0: c = CH_LOWER_N;
          1: c = CH_ZERO;
          2: c = CH_QUOTE;
          3: c = CH_BACKSLASH;
          default: c = 8'($urandom_range(0, 255));
        endcase
        send_item(c, 1'b0);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
        send_item(c, 1'b0);
      end
    end
    if (terminated) send_item(CH_QUOTE, 1'b0);
    else send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // one random piece of source text
  task automatic send_fragment();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_item($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : CH_UNDERSCORE, 1'b0);
      repeat ($urandom_range(0, 5)) send_item(rand_word_byte(), 1'b0);
      send_item(rand_separator(), 1'b0);
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 3)) send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      send_item(CH_DOT, 1'b0);
      repeat ($urandom_range(0, 3)) send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 3) == 0) send_item(CH_DOT, 1'b0);
    end else if (pick < 52) begin
      send_item(sym_chars[$urandom_range(0, sym_chars.len() - 1)], 1'b0);
    end else if (pick < 62) begin
      send_item(CH_EQUAL, 1'b0);
      if ($urandom_range(0, 1)) send_item(CH_EQUAL, 1'b0);
    end else if (pick < 77) begin
      send_char_literal($urandom_range(0, 9) != 0);
    end else if (pick < 85) begin
      send_item(rand_separator(), 1'b0);
    end else if (pick < 92) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // runs, dot after digit, non-ascii separator, end of text inside a run
  task automatic test_runs();
    send_text("a9..");
    send_item(8'hFF, 1'b0);
    send_item(CH_UNDERSCORE, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // lone equals, double equals, symbol after equals, end of text after equals
  task automatic test_equals();
    send_text("===+=");
    send_item(8'h00, 1'b1);
  endtask

  // literal with a high byte, escapes, a dropped escape, end of text in an escape
  task automatic test_char_literal();
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("\\n\\0\\'\\q\\");
    send_item(8'hFF, 1'b1);
  endtask

  // end of text with no pending word, then inside an open literal
  task automatic test_end_of_text();
    send_item(8'hA5, 1'b1);
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  // random stream with a stretch of no idling and a full drain in between
  task automatic test_random_stream();
    bit drained;
    drained = 1'b0;
    sent_requests = 0;
    while (sent_requests < 280) begin
      idle_on = !(sent_requests >= 100 && sent_requests < 180);
      if (!drained && sent_requests >= 180) begin
        wait_for_results();
        drained = 1'b1;
      end
      send_fragment();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    idle_on            = 1'b1;
    mismatch_count     = 0;
    sent_requests      = 0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = 8'h00;
    in_if.end_of_text  = 1'b0;
    tok_mode           = MODE_IDLE;
    tok_after_digit    = 1'b0;
    tok_word_open      = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_runs();
    test_equals();
    wait_for_results();
    test_char_literal();
    test_end_of_text();
    test_random_stream();

    // drain and let any stray result show up
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && token_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", token_expect_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
